### rtl/tsht_pkg.sv
`default_nettype none
package tsht_pkg;

    localparam int OP_W     = 3;
    localparam int COORD_W  = 16;
    localparam int SPAN_W   = 12;
    localparam int SCOLS_W  = 13;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [PADDR_W-1:0] ADDR_SCREEN_COLS = 2'd0;
    localparam logic [SCOLS_W-1:0] SCREEN_COLS_RESET = 13'd80;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_START  = 3'd1,
        OP_UPDATE = 3'd2,
        OP_FINISH = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef struct packed {
        logic                      active;
        logic                      rect_mode;
        logic signed [COORD_W-1:0] anchor_col;
        logic signed [COORD_W-1:0] anchor_row;
        logic signed [COORD_W-1:0] end_col;
        logic signed [COORD_W-1:0] end_row;
    } sel_t;

    typedef struct packed {
        logic              row_hit;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              cell_selected;
    } hit_t;

endpackage
`default_nettype wire

### rtl/tsht_span.sv
`default_nettype none
module tsht_span #(
    parameter int WIDTH_W = 13
) (
    input  tsht_pkg::sel_t                      sel,
    input  logic [WIDTH_W-1:0]                  sel_width,
    input  logic signed [tsht_pkg::COORD_W-1:0] col,
    input  logic signed [tsht_pkg::COORD_W-1:0] row,
    output tsht_pkg::hit_t                      hit
);
    import tsht_pkg::*;

    localparam int EXT_W = COORD_W + 1;

    logic signed [COORD_W-1:0] top_row;
    logic signed [COORD_W-1:0] bot_row;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] bot_x;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic                      down;
    logic                      in_rows;
    logic signed [EXT_W-1:0]   w_ext;
    logic signed [EXT_W-1:0]   w_m1;
    logic signed [EXT_W-1:0]   col_ext;
    logic signed [EXT_W-1:0]   xs_raw;
    logic signed [EXT_W-1:0]   xe_raw;
    logic signed [EXT_W-1:0]   xs;
    logic signed [EXT_W-1:0]   xe;
    logic                      row_hit;

    always_comb
    begin
        down    = sel.anchor_row <= sel.end_row;
        top_row = down ? sel.anchor_row : sel.end_row;
        bot_row = down ? sel.end_row : sel.anchor_row;
        top_x   = down ? sel.anchor_col : sel.end_col;
        bot_x   = down ? sel.end_col : sel.anchor_col;
        min_x   = (sel.anchor_col <= sel.end_col) ? sel.anchor_col : sel.end_col;
        max_x   = (sel.anchor_col <= sel.end_col) ? sel.end_col : sel.anchor_col;
        in_rows = sel.active && (row >= top_row) && (row <= bot_row);
        w_ext   = $signed(EXT_W'(sel_width));
        w_m1    = w_ext - EXT_W'(1);
        col_ext = EXT_W'(col);

        if (sel.rect_mode || (top_row == bot_row))
        begin
            xs_raw = EXT_W'(min_x);
            xe_raw = EXT_W'(max_x);
        end
        else if (row == top_row)
        begin
            xs_raw = EXT_W'(top_x);
            xe_raw = w_m1;
        end
        else if (row == bot_row)
        begin
            xs_raw = '0;
            xe_raw = EXT_W'(bot_x);
        end
        else
        begin
            xs_raw = '0;
            xe_raw = w_m1;
        end

        xs = (xs_raw < 0) ? '0 : xs_raw;
        xe = (xe_raw >= w_ext) ? w_m1 : xe_raw;
        row_hit = in_rows && (xs <= xe);

        hit.row_hit       = row_hit;
        hit.span_start    = row_hit ? xs[SPAN_W-1:0] : '0;
        hit.span_end      = row_hit ? xe[SPAN_W-1:0] : '0;
        hit.cell_selected = row_hit && (col_ext >= xs) && (col_ext <= xe);
    end

endmodule
`default_nettype wire

### rtl/text_selection_hit_test.sv
// Channel  Direction  Handshake                 Payload
// cfg      in         psel/penable/pwrite/pready paddr, pwdata, prdata
// in       in         in_valid/in_ready          op, col, row, rect_select
// out      out        out_valid/out_ready        row_hit, span_start, span_end, cell_selected
//
// One beat per clock unless out stalls; a beat passes the input, then the result register.
// Selection state updates as a beat leaves the input register, so a query sees all earlier ops.
// rst_n clears the selection, the flags and screen_cols (80); payload registers are not reset.
// A stalled result holds both registers; in_ready drops only when both are full and out stalls.
`default_nettype none
module text_selection_hit_test #(
    parameter int MAX_COLS = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tsht_pkg::PADDR_W-1:0]          paddr,
    input  logic [tsht_pkg::PDATA_W-1:0]          pwdata,
    output logic [tsht_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tsht_pkg::OP_W-1:0]             op,
    input  logic signed [tsht_pkg::COORD_W-1:0]   col,
    input  logic signed [tsht_pkg::COORD_W-1:0]   row,
    input  logic                                  rect_select,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  row_hit,
    output logic [tsht_pkg::SPAN_W-1:0]           span_start,
    output logic [tsht_pkg::SPAN_W-1:0]           span_end,
    output logic                                  cell_selected
);
    import tsht_pkg::*;

    localparam int WIDTH_W     = $clog2(MAX_COLS + 1);
    localparam int WIDTH_RESET = (MAX_COLS < 80) ? MAX_COLS : 80;
    localparam int CMP_W       = 16;

    logic [SCOLS_W-1:0]        screen_cols_reg;
    logic [WIDTH_W-1:0]        sel_width_reg;
    logic [WIDTH_W-1:0]        sel_width_next;
    sel_t                      sel_reg;
    sel_t                      sel_next;
    logic                      drag_pending_reg;
    logic                      drag_pending_next;

    logic                      s1_valid_reg;
    logic [OP_W-1:0]           s1_op_reg;
    logic signed [COORD_W-1:0] s1_col_reg;
    logic signed [COORD_W-1:0] s1_row_reg;
    logic                      s1_rect_reg;

    logic                      out_valid_reg;
    hit_t                      out_reg;
    hit_t                      out_next;
    hit_t                      hit;

    logic                      advance;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign prdata    = PDATA_W'(screen_cols_reg);
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_SCREEN_COLS);

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    tsht_span #(
        .WIDTH_W (WIDTH_W)
    ) u_span (
        .sel       (sel_reg),
        .sel_width (sel_width_reg),
        .col       (s1_col_reg),
        .row       (s1_row_reg),
        .hit       (hit)
    );

    always_comb
    begin
        sel_next          = sel_reg;
        drag_pending_next = drag_pending_reg;
        sel_width_next    = sel_width_reg;
        out_next          = '0;
        case (s1_op_reg)
            OP_CLEAR:
            begin
                sel_next.active   = 1'b0;
                sel_next.rect_mode = 1'b0;
                drag_pending_next = 1'b0;
            end
            OP_START:
            begin
                sel_next.anchor_col = s1_col_reg;
                sel_next.anchor_row = s1_row_reg;
                sel_next.end_col    = s1_col_reg;
                sel_next.end_row    = s1_row_reg;
                sel_next.rect_mode  = s1_rect_reg;
                sel_next.active     = 1'b1;
                drag_pending_next   = 1'b1;
                if (CMP_W'(screen_cols_reg) > CMP_W'(MAX_COLS))
                    sel_width_next = WIDTH_W'(MAX_COLS);
                else
                    sel_width_next = WIDTH_W'(screen_cols_reg);
            end
            OP_UPDATE:
            begin
                if (drag_pending_reg)
                begin
                    sel_next.end_col = s1_col_reg;
                    sel_next.end_row = s1_row_reg;
                end
            end
            OP_FINISH:
            begin
                drag_pending_next = 1'b0;
            end
            OP_QUERY:
            begin
                out_next = hit;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_cols_reg  <= SCREEN_COLS_RESET;
            sel_width_reg    <= WIDTH_W'(WIDTH_RESET);
            sel_reg          <= '0;
            drag_pending_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                screen_cols_reg <= pwdata[SCOLS_W-1:0];
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                sel_reg          <= sel_next;
                drag_pending_reg <= drag_pending_next;
                sel_width_reg    <= sel_width_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg   <= op;
            s1_col_reg  <= col;
            s1_row_reg  <= row;
            s1_rect_reg <= rect_select;
        end
        if (advance)
            out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign row_hit       = out_reg.row_hit;
    assign span_start    = out_reg.span_start;
    assign span_end      = out_reg.span_end;
    assign cell_selected = out_reg.cell_selected;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        drag_pending_reg |-> sel_reg.active)
        else $error("drag pending without an active selection");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.cell_selected |-> out_reg.row_hit)
        else $error("cell selected on a row without a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.row_hit |->
            (out_reg.span_start == '0) && (out_reg.span_end == '0))
        else $error("nonzero span on a miss");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_op_reg))
        else $error("input beat dropped while result stalled");
`endif

endmodule
`default_nettype wire

### bench/tsht_selection_checker.sv
`timescale 1ns / 100ps
module tsht_selection_checker #(
    parameter int WIDTH_CAP = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [tsht_pkg::PADDR_W-1:0]        paddr,
    input  logic [tsht_pkg::PDATA_W-1:0]        pwdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [tsht_pkg::OP_W-1:0]           op,
    input  logic signed [tsht_pkg::COORD_W-1:0] col,
    input  logic signed [tsht_pkg::COORD_W-1:0] row,
    input  logic                                rect_select,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                row_hit,
    input  logic [tsht_pkg::SPAN_W-1:0]         span_start,
    input  logic [tsht_pkg::SPAN_W-1:0]         span_end,
    input  logic                                cell_selected,
    output int                                  fail_count,
    output int                                  pending_results
);
    import tsht_pkg::*;

    logic               have_sel = 1'b0;
    logic               dragging = 1'b0;
    logic               rect_shape = 1'b0;
    int                 anc_c = 0;
    int                 anc_r = 0;
    int                 tip_c = 0;
    int                 tip_r = 0;
    int                 frozen_width = 80;
    logic [SCOLS_W-1:0] cols_reg = SCREEN_COLS_RESET;
    hit_t               expected_spans[$];
    int                 mismatches = 0;
    int                 waiting = 0;

    assign fail_count = mismatches;
    assign pending_results = waiting;

    task automatic track_event(input logic [OP_W-1:0] code, input logic signed [COORD_W-1:0] c16,
                               input logic signed [COORD_W-1:0] r16, input logic rect);
        int   c;
        int   r;
        int   top;
        int   bot;
        int   xs;
        int   xe;
        logic down;
        hit_t res;
        c = c16;
        r = r16;
        res = '0;
        case (code)
            OP_CLEAR:
            begin
                have_sel = 1'b0;
                dragging = 1'b0;
                rect_shape = 1'b0;
            end
            OP_START:
            begin
                anc_c = c;
                anc_r = r;
                tip_c = c;
                tip_r = r;
                frozen_width = (int'(cols_reg) > WIDTH_CAP) ? WIDTH_CAP : int'(cols_reg);
                rect_shape = rect;
                have_sel = 1'b1;
                dragging = 1'b1;
            end
            OP_UPDATE:
            begin
                if (dragging)
                begin
                    tip_c = c;
                    tip_r = r;
                end
            end
            OP_FINISH:
            begin
                dragging = 1'b0;
            end
            OP_QUERY:
            begin
                top = (anc_r < tip_r) ? anc_r : tip_r;
                bot = (anc_r > tip_r) ? anc_r : tip_r;
                if (have_sel && r >= top && r <= bot)
                begin
                    if (rect_shape || top == bot)
                    begin
                        xs = (anc_c < tip_c) ? anc_c : tip_c;
                        xe = (anc_c > tip_c) ? anc_c : tip_c;
                    end
                    else
                    begin
                        down = (anc_r <= tip_r);
                        xs = 0;
                        xe = frozen_width - 1;
                        if (r == top)
                            xs = down ? anc_c : tip_c;
                        else if (r == bot)
                            xe = down ? tip_c : anc_c;
                    end
                    if (xs < 0)
                        xs = 0;
                    if (xe >= frozen_width)
                        xe = frozen_width - 1;
                    if (xs <= xe)
                    begin
                        res.row_hit = 1'b1;
                        res.span_start = xs[SPAN_W-1:0];
                        res.span_end = xe[SPAN_W-1:0];
                        res.cell_selected = (c >= xs && c <= xe);
                    end
                end
            end
            default:
            begin
            end
        endcase
        expected_spans.push_back(res);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        hit_t want;
        if (expected_spans.size() == 0)
        begin
            $display("%0t: result beat expected none actual %b/%0d/%0d/%b", $time,
                     row_hit, span_start, span_end, cell_selected);
            mismatches++;
        end
        else
        begin
            want = expected_spans.pop_front();
            compare_field("row_hit", want.row_hit, row_hit);
            compare_field("span_start", want.span_start, span_start);
            compare_field("span_end", want.span_end, span_end);
            compare_field("cell_selected", want.cell_selected, cell_selected);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_sel = 1'b0;
            dragging = 1'b0;
            rect_shape = 1'b0;
            anc_c = 0;
            anc_r = 0;
            tip_c = 0;
            tip_r = 0;
            frozen_width = 80;
            cols_reg = SCREEN_COLS_RESET;
            expected_spans.delete();
            waiting = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SCREEN_COLS)
                cols_reg = pwdata[SCOLS_W-1:0];
            if (out_valid && out_ready)
                check_beat();
            if (in_valid && in_ready)
                track_event(op, col, row, rect_select);
            waiting = expected_spans.size();
        end
    end

endmodule

### bench/tb_text_selection_hit_test.sv
`timescale 1ns / 100ps
module tb_text_selection_hit_test;
    import tsht_pkg::*;

    localparam int WIDTH_CAP = 4096;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [OP_W-1:0]           op = OP_CLEAR;
    logic signed [COORD_W-1:0] col = '0;
    logic signed [COORD_W-1:0] row = '0;
    logic                      rect_select = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      row_hit;
    logic [SPAN_W-1:0]         span_start;
    logic [SPAN_W-1:0]         span_end;
    logic                      cell_selected;
    int                        fail_count;
    int                        pending_results;

    int gap_max = 15;
    int stall_max = 15;
    int stall_left = 0;
    int stall_draw;
    int plan[7] = '{4096, 1, 8191, 0, 4097, 37, 80};

    text_selection_hit_test #(.MAX_COLS(WIDTH_CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .col(col), .row(row), .rect_select(rect_select),
        .out_valid(out_valid), .out_ready(out_ready),
        .row_hit(row_hit), .span_start(span_start), .span_end(span_end),
        .cell_selected(cell_selected)
    );

    tsht_selection_checker #(.WIDTH_CAP(WIDTH_CAP)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .col(col), .row(row), .rect_select(rect_select),
        .out_valid(out_valid), .out_ready(out_ready),
        .row_hit(row_hit), .span_start(span_start), .span_end(span_end),
        .cell_selected(cell_selected),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hold ready low for a drawn number of cycles after each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (out_ready)
        begin
            if (out_valid)
            begin
                stall_draw = $urandom_range(0, stall_max);
                if (stall_draw != 0)
                begin
                    out_ready <= 1'b0;
                    stall_left <= stall_draw;
                end
            end
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else
            out_ready <= 1'b1;
    end

    task automatic send_beat(input logic [OP_W-1:0] code, input logic signed [COORD_W-1:0] c,
                             input logic signed [COORD_W-1:0] r, input logic rect);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        col <= c;
        row <= r;
        rect_select <= rect;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cols(input int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_SCREEN_COLS;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_col(input int w);
        int lim;
        lim = (w > 4200) ? 4200 : w;
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: return COORD_W'(-int'($urandom_range(1, 8)));
            default: return COORD_W'($urandom_range(0, lim + 4));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_row();
        if ($urandom_range(0, 15) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 24)) - 3);
    endfunction

    task automatic send_query(input int w);
        send_beat(OP_QUERY, pick_col(w), pick_row(), 1'($urandom));
    endtask

    task automatic run_phase(input int items, input int w);
        int sent;
        int k;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_beat(OP_W'($urandom), COORD_W'($urandom), pick_row(), 1'($urandom));
                sent++;
            end
            else
            begin
                send_beat(OP_START, pick_col(w), pick_row(), 1'($urandom));
                sent++;
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    send_beat(OP_UPDATE, pick_col(w), pick_row(), 1'($urandom));
                    sent++;
                    repeat ($urandom_range(1, 4))
                    begin
                        send_query(w);
                        sent++;
                    end
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    send_beat(OP_FINISH, pick_col(w), pick_row(), 1'($urandom));
                    sent++;
                end
                repeat ($urandom_range(2, 6))
                begin
                    send_query(w);
                    sent++;
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    send_beat(OP_CLEAR, pick_col(w), pick_row(), 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing selected yet, stray update, unused codes
        send_beat(OP_QUERY, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_UPDATE, 16'sd5, 16'sd5, 1'b0);
        send_beat(OP_UNUSED_FIRST, -16'sd32768, 16'sd32767, 1'b1);
        send_beat(OP_UNUSED_LAST, 16'sd32767, -16'sd32768, 1'b0);
        // stream drag upward across rows
        send_beat(OP_START, 16'sd10, 16'sd6, 1'b0);
        send_beat(OP_UPDATE, 16'sd70, 16'sd2, 1'b0);
        send_beat(OP_QUERY, 16'sd5, 16'sd1, 1'b0);
        send_beat(OP_QUERY, 16'sd70, 16'sd2, 1'b0);
        send_beat(OP_QUERY, 16'sd79, 16'sd4, 1'b0);
        send_beat(OP_QUERY, 16'sd11, 16'sd6, 1'b0);
        send_beat(OP_FINISH, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_UPDATE, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_QUERY, 16'sd40, 16'sd4, 1'b0);
        // rectangle clamped on both sides
        send_beat(OP_START, -16'sd5, 16'sd3, 1'b1);
        send_beat(OP_UPDATE, 16'sd200, 16'sd3, 1'b0);
        send_beat(OP_QUERY, -16'sd1, 16'sd3, 1'b0);
        send_beat(OP_QUERY, 16'sd32767, 16'sd3, 1'b0);
        send_beat(OP_CLEAR, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_QUERY, 16'sd0, 16'sd3, 1'b0);
        // rectangle entirely off screen
        send_beat(OP_START, 16'sd100, 16'sd0, 1'b1);
        send_beat(OP_QUERY, 16'sd100, 16'sd0, 1'b0);
        // full coordinate range
        send_beat(OP_START, -16'sd32768, -16'sd32768, 1'b0);
        send_beat(OP_UPDATE, 16'sd32767, 16'sd32767, 1'b0);
        send_beat(OP_QUERY, -16'sd32768, -16'sd32768, 1'b0);
        send_beat(OP_QUERY, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_QUERY, 16'sd32767, 16'sd32767, 1'b0);
        drain();

        plan[5] = $urandom_range(2, 300);
        for (int i = 0; i < 7; i++)
        begin
            gap_max = (i % 2 == 0) ? 0 : 15;
            stall_max = ((i / 2) % 2 == 0) ? 0 : 15;
            write_cols(plan[i]);
            run_phase(200, plan[i]);
            drain();
        end

        if (fail_count == 0 && pending_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
